FILE: design/twdbs_pkg.sv
// Package for the two-wire display bus slave: opcodes, constants, result type.
// No dependencies; used by twdbs_core and two_wire_display_bus_slave.
package twdbs_pkg;

	// Pin-change event kind
	typedef enum logic {
		OP_DATA  = 1'b0,
		OP_CLOCK = 1'b1
	} opcode_t;

	localparam int unsigned CNT_W       = 16;  // bit counter width
	localparam int unsigned POS_W       = 4;   // position in the button frame
	localparam int unsigned SHOWN_BYTES = 5;   // payload bytes visible at the port
	localparam int unsigned PAYLOAD_W   = 8 * SHOWN_BYTES;

	localparam logic [POS_W-1:0] FRAME_LAST   = 4'd9;      // stop-bit slot
	localparam logic [7:0]       BRIGHT_MASK  = 8'hC0;
	localparam logic [7:0]       BRIGHT_MATCH = 8'h80;     // 10xxxxxx
	localparam logic [CNT_W-1:0] CMD_LAST_BIT = 16'd7;
	localparam logic [CNT_W-1:0] CNT_MAX      = 16'hFFFF;
	localparam logic [7:0]       BRIGHT_RESET = 8'd7;

	typedef struct packed {
		logic                 td_level;
		logic                 packet_done;
		logic                 transfer_active;
		logic [7:0]           command_byte;
		logic [7:0]           brightness_code;
		logic [PAYLOAD_W-1:0] payload_bytes;
	} result_t;

endpackage

FILE: design/twdbs_core.sv
// Bus state and per-event update for the two-wire display bus slave.
// Depends on twdbs_pkg; instantiated by two_wire_display_bus_slave.
module twdbs_core #(
	parameter int unsigned PAYLOAD_BYTES = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic                         opcode,
	input  logic                         clk_level,
	input  logic                         ld_level,
	input  logic [7:0]                   button_code,
	input  logic [7:0]                   payload_command,
	output twdbs_pkg::result_t           res
);

	localparam int unsigned IDX_W = twdbs_pkg::CNT_W - 3;

	logic [twdbs_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic [twdbs_pkg::POS_W-1:0] pos_q, pos_d;
	logic [7:0]                  cmd_q, cmd_d;
	logic [7:0]                  bright_q, bright_d;
	logic                        act_q, act_d;
	logic                        td_q, td_d;
	logic                        done;
	logic [7:0]                  store_q [PAYLOAD_BYTES];
	logic [7:0]                  store_d [PAYLOAD_BYTES];

	logic [2:0]       bitpos;
	logic [IDX_W-1:0] byte_idx;
	logic [9:0]       frame;

	assign bitpos   = cnt_q[2:0];
	assign byte_idx = cnt_q[twdbs_pkg::CNT_W-1:3];
	// start 0, button LSB first, stop 1
	assign frame    = {1'b1, button_code, 1'b0};

	always_comb begin
		cnt_d    = cnt_q;
		pos_d    = pos_q;
		cmd_d    = cmd_q;
		bright_d = bright_q;
		act_d    = act_q;
		td_d     = td_q;
		done     = 1'b0;
		store_d  = store_q;
		if (opcode == twdbs_pkg::OP_DATA) begin
			if (clk_level) begin
				// frame boundary: start or stop condition
				cnt_d = '0;
				pos_d = '0;
				cmd_d = '0;
				done  = ld_level;
				act_d = ~ld_level;
			end
		end else if (clk_level) begin
			if (byte_idx == '0) begin
				cmd_d = cmd_q | (8'(ld_level) << bitpos);
			end
			for (int i = 0; i < PAYLOAD_BYTES; i++) begin
				if (byte_idx == IDX_W'(i + 1) && cmd_q == payload_command) begin
					store_d[i][bitpos] = ld_level;
				end
			end
			if (cnt_q == twdbs_pkg::CMD_LAST_BIT &&
			    (cmd_d & twdbs_pkg::BRIGHT_MASK) == twdbs_pkg::BRIGHT_MATCH) begin
				bright_d = cmd_d;
			end
			cnt_d = cnt_q + 1'b1;
			// frame position tracks cnt mod 10, including the 2^16 wrap
			if (cnt_q == twdbs_pkg::CNT_MAX || pos_q == twdbs_pkg::FRAME_LAST) begin
				pos_d = '0;
			end else begin
				pos_d = pos_q + 1'b1;
			end
		end else begin
			td_d = frame[pos_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			pos_q    <= '0;
			cmd_q    <= '0;
			bright_q <= twdbs_pkg::BRIGHT_RESET;
			act_q    <= 1'b0;
			td_q     <= 1'b1;
			for (int i = 0; i < PAYLOAD_BYTES; i++) begin
				store_q[i] <= '0;
			end
		end else if (fire) begin
			cnt_q    <= cnt_d;
			pos_q    <= pos_d;
			cmd_q    <= cmd_d;
			bright_q <= bright_d;
			act_q    <= act_d;
			td_q     <= td_d;
			store_q  <= store_d;
		end
	end

	// Result reflects the state after this event
	logic [twdbs_pkg::PAYLOAD_W-1:0] packed_pl;

	for (genvar g = 0; g < twdbs_pkg::SHOWN_BYTES; g++) begin : g_pack
		if (g < PAYLOAD_BYTES) begin : g_byte
			assign packed_pl[8*g +: 8] = store_d[g];
		end else begin : g_zero
			assign packed_pl[8*g +: 8] = 8'd0;
		end
	end

	always_comb begin
		res.td_level        = td_d;
		res.packet_done     = done;
		res.transfer_active = act_d;
		res.command_byte    = cmd_d;
		res.brightness_code = bright_d;
		res.payload_bytes   = packed_pl;
	end

endmodule

FILE: design/two_wire_display_bus_slave.sv
// Top level of the two-wire display bus slave: config register and output skid.
// Depends on twdbs_pkg and twdbs_core.
//
// Usage: each input transfer is one pin-change event (opcode, clk_level, ld_level,
// button_code). Every event yields exactly one result transfer carrying the transmit
// level, packet-done and active flags, command byte, brightness byte and the stored
// payload bytes as they stand after the event.
// Each result is registered before it is presented; a stall can hold it in the skid entry.
// Throughput: one event per cycle while in_stall is low. The state update is a single
// registered pass in twdbs_core, so back-to-back events never wait on each other.
// Stalls: the output has a result register plus one skid entry. A stalled output
// parks the next result in the skid entry; in_stall rises only while that entry is
// full and drops as soon as the receiver takes the held result.
// Reset: arst_n clears counters, command, payload store and flags, sets brightness
// to 7 and the transmit line idle high, and empties the output stage.
// Config: cfg_we writes payload_command; write it only while no event is in flight.
module two_wire_display_bus_slave #(
	parameter int unsigned PAYLOAD_BYTES = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic        clk_level,
	input  logic        ld_level,
	input  logic [7:0]  button_code,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        td_level,
	output logic        packet_done,
	output logic        transfer_active,
	output logic [7:0]  command_byte,
	output logic [7:0]  brightness_code,
	output logic [39:0] payload_bytes
);

	logic [7:0]         pcmd_q;
	logic               in_fire;
	logic               out_take;
	logic               out_vld_q;
	logic               skid_vld_q;
	twdbs_pkg::result_t new_res;
	twdbs_pkg::result_t res_q;
	twdbs_pkg::result_t skid_q;

	// payload_command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcmd_q <= '0;
		end else if (cfg_we) begin
			pcmd_q <= cfg_wdata;
		end
	end

	// Only a full skid entry holds off the sender
	assign in_stall = skid_vld_q;
	assign in_fire  = in_valid && !skid_vld_q;
	assign out_take = out_vld_q && !out_stall;

	twdbs_core #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (in_fire),
		.opcode         (opcode),
		.clk_level      (clk_level),
		.ld_level       (ld_level),
		.button_code    (button_code),
		.payload_command(pcmd_q),
		.res            (new_res)
	);

	// Output stage control: result register and one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			// skid drains into the result register once the receiver takes
			if (out_take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (in_fire) begin
			if (out_vld_q && out_stall) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (out_take) begin
			out_vld_q <= 1'b0;
		end
	end

	// Output stage data, same steering as above
	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_take) begin
				res_q <= skid_q;
			end
		end else if (in_fire) begin
			if (out_vld_q && out_stall) begin
				skid_q <= new_res;
			end else begin
				res_q <= new_res;
			end
		end
	end

	assign out_valid       = out_vld_q;
	assign td_level        = res_q.td_level;
	assign packet_done     = res_q.packet_done;
	assign transfer_active = res_q.transfer_active;
	assign command_byte    = res_q.command_byte;
	assign brightness_code = res_q.brightness_code;
	assign payload_bytes   = res_q.payload_bytes;

	// The skid entry is only ever occupied behind a held result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry valid with empty result register");

	// The skid entry fills only when the result register was stalled
	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!skid_vld_q && in_fire |=> skid_vld_q == $past(out_vld_q && out_stall))
		else $error("skid entry filled without an output stall");

	// A draining skid entry lands in the result register unchanged
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && !out_stall |=> out_vld_q && !skid_vld_q && res_q == $past(skid_q))
		else $error("skid entry lost or corrupted on drain");

endmodule

FILE: verif/two_wire_display_bus_slave_tb.sv
// Testbench for two_wire_display_bus_slave: pin-change events in, one bus state out per event.
// Needs twdbs_pkg and the RTL of two_wire_display_bus_slave; checks against a built-in predictor.
// Directed frames, payload storage and random bus traffic with and without random idling.
module two_wire_display_bus_slave_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PAYLOAD_BYTES = 5;
	localparam int unsigned FRAME_BITS    = 10;   // start, eight button bits, stop
	localparam int unsigned DRAIN_CYCLES  = 4;    // covers the result register and the skid entry
	localparam int unsigned IDLE_LIMIT    = 1000; // cycles with no transfer before giving up
	localparam int unsigned REPORT_MAX    = 60;   // keeps the log short on a broken build

	// One pin-change event as the sender sees it
	typedef struct packed {
		twdbs_pkg::opcode_t op;
		logic               clk_lv;
		logic               ld_lv;
		logic [7:0]         button;
	} pin_event_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        opcode;
	logic        clk_level;
	logic        ld_level;
	logic [7:0]  button_code;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        out_valid;
	logic        out_stall;
	logic        td_level;
	logic        packet_done;
	logic        transfer_active;
	logic [7:0]  command_byte;
	logic [7:0]  brightness_code;
	logic [39:0] payload_bytes;

	two_wire_display_bus_slave #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.clk_level      (clk_level),
		.ld_level       (ld_level),
		.button_code    (button_code),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.td_level       (td_level),
		.packet_done    (packet_done),
		.transfer_active(transfer_active),
		.command_byte   (command_byte),
		.brightness_code(brightness_code),
		.payload_bytes  (payload_bytes)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predicted slave state. Updated once per accepted input transfer.
	// ------------------------------------------------------------------
	logic [15:0] bit_cnt   = '0;
	logic [7:0]  cmd_q     = '0;
	logic [7:0]  store_q [PAYLOAD_BYTES];
	logic [7:0]  bright_q  = twdbs_pkg::BRIGHT_RESET;
	logic        active_q  = 1'b0;
	logic        td_q      = 1'b1;      // transmit line idles high
	logic [7:0]  pay_cmd_q = '0;        // mirror of payload_command

	twdbs_pkg::result_t expected_bus_state[$];  // one entry per accepted event, oldest first

	bit gaps_on  = 1'b0;                // sender inserts idle bursts
	bit stall_on = 1'b0;                // receiver inserts stall bursts
	int unsigned sent_items = 0;
	int unsigned mismatches = 0;

	// Bus state after one pin event; also advances the predicted state.
	function automatic twdbs_pkg::result_t advance_bus_state(pin_event_t ev);
		twdbs_pkg::result_t r;
		logic [12:0]        byte_idx;
		logic [2:0]         bitpos;
		logic [9:0]         tx_frame;
		r.packet_done = 1'b0;
		if (ev.op == twdbs_pkg::OP_DATA) begin
			// Data edge only matters while the clock line is high: frame boundary.
			// Low data after it is a start condition, high data a stop condition.
			if (ev.clk_lv) begin
				bit_cnt       = '0;
				cmd_q         = '0;
				r.packet_done = ev.ld_lv;
				active_q      = ~ev.ld_lv;
			end
		end else if (ev.clk_lv) begin
			// Rising clock: sample the data line, LSB first
			bitpos   = bit_cnt[2:0];
			byte_idx = bit_cnt[15:3];
			if (byte_idx == 0)
				cmd_q[bitpos] = cmd_q[bitpos] | ev.ld_lv;
			else if (byte_idx <= PAYLOAD_BYTES && cmd_q == pay_cmd_q)
				store_q[byte_idx-1][bitpos] = ev.ld_lv;
			// brightness takes the full command, bit 7 included
			if (bit_cnt == twdbs_pkg::CMD_LAST_BIT &&
			    (cmd_q & twdbs_pkg::BRIGHT_MASK) == twdbs_pkg::BRIGHT_MATCH)
				bright_q = cmd_q;
			bit_cnt = bit_cnt + 16'd1;   // wraps at 16 bits
		end else begin
			// Falling clock: next bit of the button frame on the transmit line
			tx_frame = {1'b1, ev.button, 1'b0};
			td_q     = tx_frame[bit_cnt % FRAME_BITS];
		end
		r.td_level        = td_q;
		r.transfer_active = active_q;
		r.command_byte    = cmd_q;
		r.brightness_code = bright_q;
		r.payload_bytes   = '0;
		for (int i = 0; i < PAYLOAD_BYTES && i < twdbs_pkg::SHOWN_BYTES; i++)
			r.payload_bytes[8*i +: 8] = store_q[i];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Sends one pin event. in_valid is left high after the transfer so that
	// back-to-back events need no extra assignment; idle bursts lower it.
	task automatic send_pin(input twdbs_pkg::opcode_t op, input logic c, input logic d,
			input logic [7:0] b);
		pin_event_t ev;
		ev.op     = op;
		ev.clk_lv = c;
		ev.ld_lv  = d;
		ev.button = b;
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		opcode      <= ev.op;
		clk_level   <= ev.clk_lv;
		ld_level    <= ev.ld_lv;
		button_code <= ev.button;
		in_valid    <= 1'b1;
		// values read right after the edge are the ones the edge saw
		do @(posedge clk); while (in_stall !== 1'b0);
		expected_bus_state.push_back(advance_bus_state(ev));
		sent_items++;
	endtask

	// Rising clocks carrying one byte LSB first, each optionally followed by a
	// falling clock that shifts out the button frame.
	task automatic send_byte(input logic [7:0] b, input bit with_falls,
			input logic [7:0] button);
		for (int i = 0; i < 8; i++) begin
			send_pin(twdbs_pkg::OP_CLOCK, 1'b1, b[i], button);
			if (with_falls)
				send_pin(twdbs_pkg::OP_CLOCK, 1'b0, b[i], button);
		end
	endtask

	// Stop sending and let every outstanding result come back.
	task automatic drain_bus();
		in_valid <= 1'b0;
		while (expected_bus_state.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Only called with the bus drained
	task automatic write_payload_command(input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		pay_cmd_q = value;
	endtask

	task automatic set_idling(input bit on);
		gaps_on  = on;
		stall_on = on;
	endtask

	// ------------------------------------------------------------------
	// Receiver side: random stall bursts raised on random cycles
	// ------------------------------------------------------------------
	int unsigned stall_left = 0;

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			if (stall_left == 0)
				out_stall <= 1'b0;
		end else if (stall_on && $urandom_range(0, 9) == 0) begin
			out_stall  <= 1'b1;
			stall_left = $urandom_range(1, 19);
		end
	end

	// ------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [39:0] exp_v,
			input logic [39:0] act_v);
		if (act_v !== exp_v) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("%t ns: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		twdbs_pkg::result_t exp_r;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_bus_state.size() == 0) begin
				mismatches++;
				$display("%t ns: result transfer with nothing expected, expected none, got %h",
					$time, {td_level, packet_done, transfer_active, command_byte,
					brightness_code, payload_bytes});
			end else begin
				exp_r = expected_bus_state.pop_front();
				check_field("td_level", 40'(exp_r.td_level), 40'(td_level));
				check_field("packet_done", 40'(exp_r.packet_done), 40'(packet_done));
				check_field("transfer_active", 40'(exp_r.transfer_active),
					40'(transfer_active));
				check_field("command_byte", 40'(exp_r.command_byte), 40'(command_byte));
				check_field("brightness_code", 40'(exp_r.brightness_code),
					40'(brightness_code));
				check_field("payload_bytes", exp_r.payload_bytes, payload_bytes);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: ends the run when no transfer happens for too long
	// ------------------------------------------------------------------
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Data edges with the clock low, a falling clock at reset, a brightness
	// command (10xxxxxx), one that is not (11xxxxxx), start and stop.
	task automatic test_quiet_and_brightness();
		set_idling(1'b1);
		write_payload_command(8'h00);
		send_pin(twdbs_pkg::OP_DATA, 1'b0, 1'b0, 8'h00);   // clock low: no effect
		send_pin(twdbs_pkg::OP_DATA, 1'b0, 1'b1, 8'hFF);
		send_pin(twdbs_pkg::OP_CLOCK, 1'b0, 1'b1, 8'hFF);  // start bit slot drives 0
		send_pin(twdbs_pkg::OP_DATA, 1'b1, 1'b0, 8'hFF);   // start condition
		send_byte(8'h8A, 1'b0, 8'hFF);                     // brightness captured at bit 7
		send_pin(twdbs_pkg::OP_CLOCK, 1'b0, 1'b0, 8'h00);  // button bit 7 slot
		send_pin(twdbs_pkg::OP_CLOCK, 1'b1, 1'b1, 8'h00);  // command mismatch: not stored
		send_pin(twdbs_pkg::OP_CLOCK, 1'b0, 1'b0, 8'h00);  // stop bit slot drives 1
		send_pin(twdbs_pkg::OP_DATA, 1'b1, 1'b1, 8'h00);   // stop condition
		send_pin(twdbs_pkg::OP_DATA, 1'b1, 1'b0, 8'h5A);
		send_byte(8'hC5, 1'b0, 8'h5A);                     // 11xxxxxx leaves brightness alone
		send_pin(twdbs_pkg::OP_DATA, 1'b1, 1'b1, 8'h5A);
	endtask

	// Full payload after a matching command, a sixth byte past the store, and
	// a frame with a different command that must leave the store untouched.
	task automatic test_payload_store();
		drain_bus();
		write_payload_command(8'h40);
		send_pin(twdbs_pkg::OP_DATA, 1'b1, 1'b0, 8'hA5);
		send_byte(8'h40, 1'b1, 8'hA5);
		send_byte(8'h00, 1'b1, 8'h3C);
		send_byte(8'hFF, 1'b0, 8'h3C);
		send_byte(8'h5A, 1'b1, 8'hFF);
		send_byte(8'hA5, 1'b0, 8'h00);
		send_byte(8'h81, 1'b1, 8'h00);
		send_byte(8'hFF, 1'b1, 8'h96);          // past the store
		send_pin(twdbs_pkg::OP_DATA, 1'b1, 1'b1, 8'h96);
		send_pin(twdbs_pkg::OP_DATA, 1'b1, 1'b0, 8'h96);
		send_byte(8'h41, 1'b0, 8'h96);
		send_byte(8'hE7, 1'b1, 8'h96);
		send_byte(8'h18, 1'b0, 8'h96);
		send_pin(twdbs_pkg::OP_DATA, 1'b1, 1'b1, 8'h96);
	endtask

	// One frame with random content: start, command, up to seven more bytes,
	// stop. Some frames are cut short, some lose their stop, and stray data
	// edges with the clock low are mixed in.
	task automatic random_frame();
		logic [7:0] cmd;
		logic [7:0] btn;
		logic [7:0] cur;
		int unsigned nbits;
		case ($urandom_range(0, 3))
			0, 1: cmd = pay_cmd_q;
			2: cmd = {2'b10, 6'($urandom_range(0, 63))};
			default: cmd = 8'($urandom_range(0, 255));
		endcase
		btn   = 8'($urandom_range(0, 255));
		nbits = 8 * (1 + ($urandom_range(0, 3) == 0 ? $urandom_range(5, 7) :
			$urandom_range(0, 3)));
		if ($urandom_range(0, 4) == 0)
			nbits = $urandom_range(1, nbits);
		send_pin(twdbs_pkg::OP_DATA, 1'b1, 1'b0, btn);
		cur = cmd;
		for (int unsigned i = 0; i < nbits; i++) begin
			if (i % 8 == 0 && i != 0)
				cur = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 15) == 0)
				btn = 8'($urandom_range(0, 255));
			send_pin(twdbs_pkg::OP_CLOCK, 1'b1, cur[i%8], btn);
			if ($urandom_range(0, 3) != 0)
				send_pin(twdbs_pkg::OP_CLOCK, 1'b0, 1'($urandom_range(0, 1)), btn);
			if ($urandom_range(0, 9) == 0)
				send_pin(twdbs_pkg::OP_DATA, 1'b0, 1'($urandom_range(0, 1)), btn);
		end
		if ($urandom_range(0, 7) != 0)
			send_pin(twdbs_pkg::OP_DATA, 1'b1, 1'b1, btn);
	endtask

	// Random traffic under one payload_command setting: mostly frames, the
	// rest short bursts of arbitrary events.
	task automatic test_random_traffic(input int unsigned items, input logic [7:0] cmd_value,
			input bit idle);
		int unsigned stop_at;
		drain_bus();
		write_payload_command(cmd_value);
		set_idling(idle);
		stop_at = sent_items + items;
		while (sent_items < stop_at) begin
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 4))
					send_pin(twdbs_pkg::opcode_t'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255)));
			end else begin
				random_frame();
			end
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		opcode      = twdbs_pkg::OP_DATA;
		clk_level   = 1'b0;
		ld_level    = 1'b0;
		button_code = '0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		out_stall   = 1'b0;
		for (int i = 0; i < PAYLOAD_BYTES; i++)
			store_q[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_quiet_and_brightness();
		test_payload_store();
		test_random_traffic(200, 8'hFF, 1'b1);
		test_random_traffic(200, 8'($urandom_range(0, 255)), 1'b1);
		test_random_traffic(200, {2'b10, 6'($urandom_range(0, 63))}, 1'b1);
		test_random_traffic(150, 8'h00, 1'b0);   // closing stretch without idling

		drain_bus();
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: filelist.f
design/twdbs_pkg.sv
design/twdbs_core.sv
design/two_wire_display_bus_slave.sv
verif/two_wire_display_bus_slave_tb.sv
